[hw/rtl/dual_axis_step_pulse_generator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual-axis step pulse generator
// Shared concurrent assertion forms, synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef DUAL_AXIS_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH
`define DUAL_AXIS_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define DASP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dasp assertion failed");

// Consequent must hold in the same clock as the antecedent.
`define DASP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dasp assertion failed");

`endif

[hw/rtl/dasp_pkg.sv]
// ----------------------------------------------------------------------------
// dasp_pkg
// Types and constants shared by the dual-axis step pulse generator files.
// ----------------------------------------------------------------------------
package dasp_pkg;

  localparam int STEP_BITS     = 24;
  localparam int ACC_BITS      = STEP_BITS + 1;
  localparam int POS_BITS      = 32;
  localparam int PERIOD_BITS   = 20;
  localparam int PULSE_BITS    = 8;
  localparam int MINP_BITS     = PULSE_BITS + 1;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = PERIOD_BITS;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET  = PERIOD_BITS'(10000);
  localparam logic [PULSE_BITS-1:0]  PULSE_RESET   = PULSE_BITS'(8);
  localparam logic [PULSE_BITS-1:0]  PULSE_FLOOR   = PULSE_BITS'(8);
  localparam logic [MINP_BITS-1:0]   PERIOD_MARGIN = MINP_BITS'(8);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_A,
    MODE_B,
    MODE_SYNC
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START_A,
    CMD_START_B,
    CMD_START_SYNC
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PERIOD,
    CFG_PULSE
  } cfg_idx_t;

endpackage

[hw/rtl/dasp_if.sv]
// ----------------------------------------------------------------------------
// dasp channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface dasp_in_if import dasp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic signed [STEP_BITS-1:0] steps_first;
  logic signed [STEP_BITS-1:0] steps_second;

  modport source (output valid, output command, output steps_first,
                  output steps_second, input ready);
  modport sink   (input valid, input command, input steps_first,
                  input steps_second, output ready);
endinterface

interface dasp_out_if import dasp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       step_a;
  logic                       step_b;
  logic                       dir_a;
  logic                       dir_b;
  logic signed [POS_BITS-1:0] position_a;
  logic signed [POS_BITS-1:0] position_b;
  logic                       busy_res;
  logic                       rejected;

  modport source (output valid, output step_a, output step_b, output dir_a,
                  output dir_b, output position_a, output position_b,
                  output busy_res, output rejected, input ready);
  modport sink   (input valid, input step_a, input step_b, input dir_a,
                  input dir_b, input position_a, input position_b,
                  input busy_res, input rejected, output ready);
endinterface

[hw/rtl/dual_axis_step_pulse_generator_unit.sv]
// ----------------------------------------------------------------------------
// dual_axis_step_pulse_generator_unit
// Two-axis stepper pulse generator with Bresenham-synced moves.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one beat per microsecond tick or start command
//   (command: tick, start A, start B, start synced; signed step counts).
//   out_chan returns exactly one result beat per input beat: step pin
//   levels, directions, wrapping positions, busy and a rejected flag.
//   cfg_we/cfg_index/cfg_data write the slot period (index 0) and the pulse
//   width (index 1); write only while no beat is in flight.
// Throughput and timing:
//   One beat per clock while out_chan does not stall. A beat accepted at an
//   edge shows its result from that edge on (out valid after it). The whole
//   update (pulse timer, slot timer, accumulator add/compare, position
//   step) is one combinational pass into the state registers.
// Stall:
//   The state registers double as the result register: while a result
//   waits, in_chan.ready follows out_chan.ready, so a beat enters in the
//   same cycle the waiting result leaves.
// Reset (rst_n low, synchronous): idle, counts and positions zero,
//   directions positive, pins low, period 10000, pulse 8, no result held.
// ----------------------------------------------------------------------------
module dual_axis_step_pulse_generator_unit import dasp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  dasp_in_if.sink                  in_chan,
  dasp_out_if.source               out_chan
);

  // configuration
  logic [PERIOD_BITS-1:0] period_r;
  logic [PULSE_BITS-1:0]  pulse_r;

  // motion state
  mode_t                  mode_r, mode_nxt;
  logic [STEP_BITS-1:0]   rem_a_r, rem_a_nxt, rem_b_r, rem_b_nxt;
  logic                   dir_a_r, dir_a_nxt, dir_b_r, dir_b_nxt;
  logic [STEP_BITS-1:0]   inc_a_r, inc_a_nxt, inc_b_r, inc_b_nxt;
  logic [STEP_BITS-1:0]   major_r, major_nxt;
  logic [ACC_BITS-1:0]    acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic [POS_BITS-1:0]    pos_a_r, pos_a_nxt, pos_b_r, pos_b_nxt;
  logic [PERIOD_BITS-1:0] slot_r, slot_nxt;
  logic [PULSE_BITS-1:0]  ptmr_r, ptmr_nxt;
  logic                   pin_a_r, pin_a_nxt, pin_b_r, pin_b_nxt;
  logic                   rej_r, rej_nxt;
  logic                   out_valid_r;

  // handshake
  logic in_ready;
  logic accept;
  cmd_t cmd;

  // derived timing
  logic [PULSE_BITS-1:0]  eff_pulse;
  logic [MINP_BITS-1:0]   min_period;
  logic [PERIOD_BITS-1:0] eff_period;
  logic [PERIOD_BITS-1:0] slot_inc;
  logic                   busy;
  logic                   slot_hit;

  // slot firing
  logic [ACC_BITS-1:0]    sum_a, sum_b;
  logic [ACC_BITS:0]      diff_a, diff_b;
  logic                   ge_a, ge_b;
  logic                   any_rem;
  logic                   da, db;
  logic [ACC_BITS-1:0]    acc_a_fire, acc_b_fire;
  logic [STEP_BITS-1:0]   rem_a_left, rem_b_left;
  logic                   slot_done;

  // start decode
  logic [STEP_BITS-1:0]   mag_first, mag_second;
  mode_t                  start_mode;

  assign cmd      = cmd_t'(in_chan.command);
  assign in_ready = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign busy       = (mode_r != MODE_IDLE);
  assign eff_pulse  = (pulse_r < PULSE_FLOOR) ? PULSE_FLOOR : pulse_r;
  assign min_period = {1'b0, eff_pulse} + PERIOD_MARGIN;
  assign eff_period = (period_r < PERIOD_BITS'(min_period)) ? PERIOD_BITS'(min_period)
                                                            : period_r;
  assign slot_inc   = slot_r + 1'b1;
  assign slot_hit   = busy && (slot_inc >= eff_period);

  assign mag_first  = in_chan.steps_first[STEP_BITS-1]
                      ? STEP_BITS'(-in_chan.steps_first) : in_chan.steps_first;
  assign mag_second = in_chan.steps_second[STEP_BITS-1]
                      ? STEP_BITS'(-in_chan.steps_second) : in_chan.steps_second;

  // Bresenham step: add own count, subtract major count on reaching it
  always_comb begin
    sum_a   = acc_a_r + ACC_BITS'(inc_a_r);
    sum_b   = acc_b_r + ACC_BITS'(inc_b_r);
    diff_a  = {1'b0, sum_a} - (ACC_BITS + 1)'(major_r);
    diff_b  = {1'b0, sum_b} - (ACC_BITS + 1)'(major_r);
    ge_a    = !diff_a[ACC_BITS];
    ge_b    = !diff_b[ACC_BITS];
    any_rem = (rem_a_r != '0) || (rem_b_r != '0);

    da         = 1'b0;
    db         = 1'b0;
    acc_a_fire = acc_a_r;
    acc_b_fire = acc_b_r;
    case (mode_r)
      MODE_A: da = (rem_a_r != '0);
      MODE_B: db = (rem_b_r != '0);
      MODE_SYNC: begin
        if (any_rem) begin
          acc_a_fire = ge_a ? diff_a[ACC_BITS-1:0] : sum_a;
          acc_b_fire = ge_b ? diff_b[ACC_BITS-1:0] : sum_b;
          da = ge_a && (rem_a_r != '0);
          db = ge_b && (rem_b_r != '0);
        end
      end
      default: ;
    endcase

    rem_a_left = da ? rem_a_r - 1'b1 : rem_a_r;
    rem_b_left = db ? rem_b_r - 1'b1 : rem_b_r;
    case (mode_r)
      MODE_A:  slot_done = (rem_a_left == '0);
      MODE_B:  slot_done = (rem_b_left == '0);
      default: slot_done = (rem_a_left == '0) && (rem_b_left == '0);
    endcase
  end

  // datapath next values
  always_comb begin
    rem_a_nxt  = rem_a_r;
    rem_b_nxt  = rem_b_r;
    dir_a_nxt  = dir_a_r;
    dir_b_nxt  = dir_b_r;
    inc_a_nxt  = inc_a_r;
    inc_b_nxt  = inc_b_r;
    major_nxt  = major_r;
    acc_a_nxt  = acc_a_r;
    acc_b_nxt  = acc_b_r;
    pos_a_nxt  = pos_a_r;
    pos_b_nxt  = pos_b_r;
    slot_nxt   = slot_r;
    ptmr_nxt   = ptmr_r;
    pin_a_nxt  = pin_a_r;
    pin_b_nxt  = pin_b_r;
    rej_nxt    = 1'b0;
    start_mode = MODE_IDLE;

    case (cmd)
      CMD_TICK: begin
        // pulse countdown first, then the slot timer
        if (ptmr_r != '0) begin
          ptmr_nxt = ptmr_r - 1'b1;
          if (ptmr_r == PULSE_BITS'(1)) begin
            pin_a_nxt = 1'b0;
            pin_b_nxt = 1'b0;
          end
        end
        if (busy) begin
          slot_nxt = slot_inc;
          if (slot_hit) begin
            slot_nxt  = '0;
            acc_a_nxt = acc_a_fire;
            acc_b_nxt = acc_b_fire;
            if (da || db) begin
              ptmr_nxt = eff_pulse;
            end
            if (da) begin
              pin_a_nxt = 1'b1;
              rem_a_nxt = rem_a_left;
              pos_a_nxt = dir_a_r ? pos_a_r + 1'b1 : pos_a_r - 1'b1;
            end
            if (db) begin
              pin_b_nxt = 1'b1;
              rem_b_nxt = rem_b_left;
              pos_b_nxt = dir_b_r ? pos_b_r + 1'b1 : pos_b_r - 1'b1;
            end
          end
        end
      end
      CMD_START_A, CMD_START_B: begin
        if (busy) begin
          rej_nxt = 1'b1;
        end else if (in_chan.steps_first != '0) begin
          slot_nxt = '0;
          if (cmd == CMD_START_A) begin
            dir_a_nxt  = !in_chan.steps_first[STEP_BITS-1];
            rem_a_nxt  = mag_first;
            start_mode = MODE_A;
          end else begin
            dir_b_nxt  = !in_chan.steps_first[STEP_BITS-1];
            rem_b_nxt  = mag_first;
            start_mode = MODE_B;
          end
        end
      end
      CMD_START_SYNC: begin
        if (busy) begin
          rej_nxt = 1'b1;
        end else if ((mag_first != '0) || (mag_second != '0)) begin
          dir_a_nxt  = !in_chan.steps_first[STEP_BITS-1];
          dir_b_nxt  = !in_chan.steps_second[STEP_BITS-1];
          rem_a_nxt  = mag_first;
          rem_b_nxt  = mag_second;
          inc_a_nxt  = mag_first;
          inc_b_nxt  = mag_second;
          major_nxt  = (mag_first > mag_second) ? mag_first : mag_second;
          acc_a_nxt  = '0;
          acc_b_nxt  = '0;
          slot_nxt   = '0;
          start_mode = MODE_SYNC;
        end
      end
      default: ;
    endcase
  end

  // motion mode next state
  always_comb begin
    mode_nxt = mode_r;
    case (cmd)
      CMD_TICK: begin
        if (slot_hit && slot_done) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        if (!busy) begin
          mode_nxt = start_mode;
        end
      end
    endcase
  end

  // result beat comes straight from the state registers
  always_comb begin
    out_chan.valid      = out_valid_r;
    out_chan.step_a     = pin_a_r;
    out_chan.step_b     = pin_b_r;
    out_chan.dir_a      = dir_a_r;
    out_chan.dir_b      = dir_b_r;
    out_chan.position_a = pos_a_r;
    out_chan.position_b = pos_b_r;
    out_chan.busy_res   = busy;
    out_chan.rejected   = rej_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      pulse_r  <= PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PERIOD: period_r <= cfg_data;
        CFG_PULSE:  pulse_r  <= cfg_data[PULSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      rem_a_r <= '0;
      rem_b_r <= '0;
      dir_a_r <= 1'b1;
      dir_b_r <= 1'b1;
      inc_a_r <= '0;
      inc_b_r <= '0;
      major_r <= '0;
      acc_a_r <= '0;
      acc_b_r <= '0;
      pos_a_r <= '0;
      pos_b_r <= '0;
      slot_r  <= '0;
      ptmr_r  <= '0;
      pin_a_r <= 1'b0;
      pin_b_r <= 1'b0;
      rej_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      dir_a_r <= dir_a_nxt;
      dir_b_r <= dir_b_nxt;
      inc_a_r <= inc_a_nxt;
      inc_b_r <= inc_b_nxt;
      major_r <= major_nxt;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      pos_a_r <= pos_a_nxt;
      pos_b_r <= pos_b_nxt;
      slot_r  <= slot_nxt;
      ptmr_r  <= ptmr_nxt;
      pin_a_r <= pin_a_nxt;
      pin_b_r <= pin_b_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule

[hw/rtl/dasp_checker.sv]
// ----------------------------------------------------------------------------
// dasp_checker
// Port-level checks for the step pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_axis_step_pulse_generator_unit_macros.svh"

module dasp_checker import dasp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_busy_res,
  input logic [POS_BITS-1:0] out_position_a,
  input logic [POS_BITS-1:0] out_position_b
);

  // a stalled result beat stays put
  `DASP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `DASP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_position_a) && $stable(out_position_b) && $stable(out_busy_res))

  // every accepted command beat yields a result in the next cycle
  `DASP_ASSERT_NEXT(a_one_cycle, clk, rst_n, in_valid && in_ready, out_valid)

  // nothing pending means the input side is open
  `DASP_ASSERT_SAME(a_empty_ready, clk, rst_n, !out_valid, in_ready)

endmodule

bind dual_axis_step_pulse_generator_unit dasp_checker u_dasp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_busy_res   (out_chan.busy_res),
  .out_position_a (out_chan.position_a),
  .out_position_b (out_chan.position_b)
);
